### rtl/lsmt_pkg.sv
// ----------------------------------------------------------------------------
// Scanline mode timer package
// Shared types, phase codes, register indexes and timing constants.
// ----------------------------------------------------------------------------
package lsmt_pkg;

    // Display phases, encoded as the status register reports them.
    typedef enum logic [1:0] {
        PH_HBLANK = 2'd0,
        PH_VBLANK = 2'd1,
        PH_OAM    = 2'd2,
        PH_XFER   = 2'd3
    } t_phase;

    // Input request kinds.
    typedef enum logic {
        REQ_TICK   = 1'b0,
        REQ_ENABLE = 1'b1
    } t_req_kind;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LINE_COMPARE = 2'd0,
        CFG_IRQ_ENABLES  = 2'd1,
        CFG_UNUSED_2     = 2'd2,
        CFG_UNUSED_3     = 2'd3
    } t_cfg_index;

    // Phase lengths in machine cycles, sized for the cycle sum.
    localparam logic [8:0] LEN_OAM    = 9'd20;
    localparam logic [8:0] LEN_XFER   = 9'd43;
    localparam logic [8:0] LEN_HBLANK = 9'd51;
    localparam logic [8:0] LEN_VLINE  = 9'd114;

    localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
    localparam logic [7:0] FRAME_LINES       = 8'd154;

    localparam logic [4:0] MAX_TICK = 5'd20;

    // Interrupt enable bit positions.
    localparam int IRQ_EN_HBLANK  = 0;
    localparam int IRQ_EN_VBLANK  = 1;
    localparam int IRQ_EN_OAM     = 2;
    localparam int IRQ_EN_COMPARE = 3;

    typedef struct packed {
        logic       mode;
        logic [4:0] cycles;
        logic       lcd_on;
    } t_in_item;

    typedef struct packed {
        logic       vblank_irq;
        logic       status_irq;
        logic [1:0] lcd_mode;
        logic [7:0] current_line;
        logic       coincidence;
        logic       render_line;
    } t_out_item;

endpackage

### rtl/lsmt_core.sv
// ----------------------------------------------------------------------------
// Scanline mode timer core
// Holds the display timing state and applies one request per step.
// ----------------------------------------------------------------------------
module lsmt_core
    import lsmt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_item   i_item,
    input  logic [7:0] i_line_compare,
    input  logic [3:0] i_irq_en,
    output t_out_item  o_result
);

    logic       r_enabled, n_enabled;
    t_phase     r_phase,   n_phase;
    logic [7:0] r_pcycles, n_pcycles;
    logic [7:0] r_line,    n_line;
    logic       r_coin,    n_coin;

    logic [4:0] tick;
    logic [8:0] sum;
    logic [8:0] rem;
    logic [7:0] line_inc;
    logic       vb, st, render;

    always_comb begin
        n_enabled = r_enabled;
        n_phase   = r_phase;
        n_pcycles = r_pcycles;
        n_line    = r_line;
        n_coin    = r_coin;
        vb        = 1'b0;
        st        = 1'b0;
        render    = 1'b0;
        tick      = (i_item.cycles > MAX_TICK) ? MAX_TICK : i_item.cycles;
        sum       = {1'b0, r_pcycles} + {4'd0, tick};
        rem       = sum;
        line_inc  = r_line + 8'd1;

        if (i_item.mode == REQ_ENABLE) begin
            if (i_item.lcd_on != r_enabled) begin
                if (i_item.lcd_on) begin
                    n_phase   = PH_OAM;
                    n_pcycles = 8'd0;
                end else begin
                    n_phase = PH_HBLANK;
                    n_coin  = 1'b0;
                    n_line  = 8'd0;
                end
            end
            n_enabled = i_item.lcd_on;
        end else if (r_enabled) begin
            case (r_phase)
                PH_HBLANK: begin
                    if (sum >= LEN_HBLANK) begin
                        rem    = sum - LEN_HBLANK;
                        n_line = line_inc;
                        if (line_inc == FIRST_VBLANK_LINE) begin
                            n_phase = PH_VBLANK;
                            vb      = 1'b1;
                            st      = i_irq_en[IRQ_EN_VBLANK];
                        end else begin
                            n_phase = PH_OAM;
                            st      = i_irq_en[IRQ_EN_OAM];
                        end
                    end
                end
                PH_VBLANK: begin
                    if (sum >= LEN_VLINE) begin
                        rem    = sum - LEN_VLINE;
                        n_line = line_inc;
                        if (line_inc == FRAME_LINES) begin
                            n_phase = PH_OAM;
                            n_line  = 8'd0;
                            st      = i_irq_en[IRQ_EN_OAM];
                        end
                    end
                end
                PH_OAM: begin
                    if (sum >= LEN_OAM) begin
                        rem     = sum - LEN_OAM;
                        n_phase = PH_XFER;
                    end
                end
                PH_XFER: begin
                    if (sum >= LEN_XFER) begin
                        rem     = sum - LEN_XFER;
                        n_phase = PH_HBLANK;
                        render  = 1'b1;
                        st      = i_irq_en[IRQ_EN_HBLANK];
                    end
                end
                default: begin
                    rem = sum;
                end
            endcase
            n_pcycles = rem[7:0];
            // The coincidence flag follows the line on every enabled tick.
            if (n_line == i_line_compare) begin
                n_coin = 1'b1;
                st     = st | i_irq_en[IRQ_EN_COMPARE];
            end else begin
                n_coin = 1'b0;
            end
        end

        o_result.vblank_irq   = vb;
        o_result.status_irq   = st;
        o_result.lcd_mode     = n_phase;
        o_result.current_line = n_line;
        o_result.coincidence  = n_coin;
        o_result.render_line  = render;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_phase   <= PH_HBLANK;
            r_pcycles <= 8'd0;
            r_line    <= 8'd0;
            r_coin    <= 1'b0;
        end else if (i_step) begin
            r_enabled <= n_enabled;
            r_phase   <= n_phase;
            r_pcycles <= n_pcycles;
            r_line    <= n_line;
            r_coin    <= n_coin;
        end
    end

    // A disabled display always sits on line zero with no coincidence.
    a_off_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enabled |-> (r_line == 8'd0) && !r_coin && (r_pcycles < 8'd134))
        else $error("disabled display holds stale line state");

    // The line counter never leaves the frame.
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line < FRAME_LINES)
        else $error("line counter beyond frame");

    // Vertical blank lines carry the vblank phase and visible lines never do.
    a_vblank_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enabled |-> ((r_line >= FIRST_VBLANK_LINE) == (r_phase == PH_VBLANK)))
        else $error("phase disagrees with line number");

    // A render pulse leaves the core in horizontal blank on a visible line.
    a_render_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.render_line |=>
            (r_phase == PH_HBLANK) && (r_line < FIRST_VBLANK_LINE))
        else $error("render pulse outside transfer end");

endmodule

### rtl/lsmt_out_reg.sv
// ----------------------------------------------------------------------------
// Scanline mode timer result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module lsmt_out_reg
    import lsmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_data,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic      r_valid;
    t_out_item r_data;

    // The slot can take a new result when empty or when being drained now.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

### rtl/lcd_scanline_mode_timer.sv
// ----------------------------------------------------------------------------
// LCD scanline mode timer
// Display timing sequencer: tracks mode, line and interrupts per request.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request either advances time by a count of machine cycles
//   (mode 0, counts above 20 count as 20) or writes the display enable bit
//   (mode 1). Every request produces exactly one result carrying the
//   interrupt pulses, the current mode, line and coincidence flag.
//   Both channels use valid/ready; a request moves on the edge where both
//   are high. The configuration channel takes the line compare value
//   (index 0) and the status interrupt enables (index 1); other indexes are
//   ignored. It is always ready and should be written only while idle.
// Data path and throughput:
//   A request lands in an input register; once the result slot is free, the
//   timing state and the result register are both updated from it at the
//   same edge. One request per cycle is sustained while the receiver keeps
//   taking results; the state update is the limiting loop.
// Reset and stall:
//   Synchronous active-low reset turns the display off, clears the state
//   and both configuration registers, and empties both stages. When the
//   receiver stalls, the result is held, the input stage fills and then
//   input ready drops until the result is taken.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer
    import lsmt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input requests.
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    // Results.
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    // Configuration writes.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_cfg_index i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_item   r_in;
    logic [7:0] r_line_compare;
    logic [3:0] r_irq_en;

    logic       out_free;
    logic       step;
    logic       cfg_wr;
    t_out_item  core_result;

    // The buffered request is processed whenever the result slot is free.
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || step;

    // Configuration writes are always accepted.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_compare <= 8'd0;
            r_irq_en       <= 4'd0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_LINE_COMPARE: r_line_compare <= i_cfg_data;
                CFG_IRQ_ENABLES:  r_irq_en       <= i_cfg_data[3:0];
                default: begin
                    r_irq_en <= r_irq_en;
                end
            endcase
        end
    end

    lsmt_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_item         (r_in),
        .i_line_compare (r_line_compare),
        .i_irq_en       (r_irq_en),
        .o_result       (core_result)
    );

    lsmt_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_data  (core_result),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

### tb/lcd_scanline_mode_timer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD scanline mode timer testbench
// Sends tick and display-enable requests over valid/ready, predicts every
// result with an independent timing model and checks it field by field,
// under several register settings and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer_tb;
    import lsmt_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int          REPORT_LIMIT    = 10;
    localparam int          ITEMS_PER_PHASE = 312;

    // Timing model of the display sequencer plus the queue of results it
    // expects, in request order.
    class scanline_scoreboard;
        logic [7:0] line_compare;
        logic [3:0] irq_enables;
        logic       display_on;
        t_phase     phase;
        logic [7:0] phase_cycles;
        logic [7:0] line_count;
        logic       coincident;
        t_out_item  expected_results[$];
        int         failures;

        function new();
            line_compare = '0;
            irq_enables  = '0;
            display_on   = 1'b0;
            phase        = PH_HBLANK;
            phase_cycles = '0;
            line_count   = '0;
            coincident   = 1'b0;
            failures     = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void write_register(t_cfg_index idx, logic [7:0] value);
            case (idx)
                CFG_LINE_COMPARE: line_compare = value;
                CFG_IRQ_ENABLES:  irq_enables  = value[3:0];
                default: ;
            endcase
        endfunction

        // Advances the model by one accepted request and queues its result.
        function void note_request(t_in_item req);
            t_out_item  res;
            logic [4:0] tick;
            logic [8:0] cycle_sum;
            res = '0;
            if (t_req_kind'(req.mode) == REQ_ENABLE) begin
                if (req.lcd_on != display_on) begin
                    if (req.lcd_on) begin
                        phase        = PH_OAM;
                        phase_cycles = '0;
                    end else begin
                        phase      = PH_HBLANK;
                        coincident = 1'b0;
                        line_count = '0;
                    end
                end
                display_on = req.lcd_on;
            end else if (display_on) begin
                tick      = (req.cycles > MAX_TICK) ? MAX_TICK : req.cycles;
                cycle_sum = {1'b0, phase_cycles} + {4'd0, tick};
                case (phase)
                    PH_HBLANK: begin
                        if (cycle_sum >= LEN_HBLANK) begin
                            cycle_sum  = cycle_sum - LEN_HBLANK;
                            line_count = line_count + 8'd1;
                            if (line_count == FIRST_VBLANK_LINE) begin
                                phase          = PH_VBLANK;
                                res.vblank_irq = 1'b1;
                                if (irq_enables[IRQ_EN_VBLANK])
                                    res.status_irq = 1'b1;
                            end else begin
                                phase = PH_OAM;
                                if (irq_enables[IRQ_EN_OAM])
                                    res.status_irq = 1'b1;
                            end
                        end
                    end
                    PH_VBLANK: begin
                        if (cycle_sum >= LEN_VLINE) begin
                            cycle_sum  = cycle_sum - LEN_VLINE;
                            line_count = line_count + 8'd1;
                            // Past the last vblank line the frame wraps.
                            if (line_count == FRAME_LINES) begin
                                phase      = PH_OAM;
                                line_count = '0;
                                if (irq_enables[IRQ_EN_OAM])
                                    res.status_irq = 1'b1;
                            end
                        end
                    end
                    PH_OAM: begin
                        if (cycle_sum >= LEN_OAM) begin
                            cycle_sum = cycle_sum - LEN_OAM;
                            phase     = PH_XFER;
                        end
                    end
                    default: begin
                        if (cycle_sum >= LEN_XFER) begin
                            cycle_sum       = cycle_sum - LEN_XFER;
                            phase           = PH_HBLANK;
                            res.render_line = 1'b1;
                            if (irq_enables[IRQ_EN_HBLANK])
                                res.status_irq = 1'b1;
                        end
                    end
                endcase
                phase_cycles = cycle_sum[7:0];
                // The compare source fires on every enabled tick that matches.
                if (line_count == line_compare) begin
                    coincident = 1'b1;
                    if (irq_enables[IRQ_EN_COMPARE])
                        res.status_irq = 1'b1;
                end else begin
                    coincident = 1'b0;
                end
            end
            res.lcd_mode     = phase;
            res.current_line = line_count;
            res.coincidence  = coincident;
            expected_results.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            logic      bad;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: result %h arrived with no request outstanding",
                             $time, got);
                return;
            end
            want = expected_results.pop_front();
            bad  = (got.vblank_irq   !== want.vblank_irq)   ||
                   (got.status_irq   !== want.status_irq)   ||
                   (got.lcd_mode     !== want.lcd_mode)     ||
                   (got.current_line !== want.current_line) ||
                   (got.coincidence  !== want.coincidence)  ||
                   (got.render_line  !== want.render_line);
            if (bad) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $write("%0t: mismatch vblank/status/mode/line/coin/render ", $time);
                    $display("expected %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                             want.vblank_irq, want.status_irq, want.lcd_mode,
                             want.current_line, want.coincidence, want.render_line,
                             got.vblank_irq, got.status_irq, got.lcd_mode,
                             got.current_line, got.coincidence, got.render_line);
                end
            end
        endfunction
    endclass

    logic       i_clk     = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_data   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    t_cfg_index cfg_index = CFG_LINE_COMPARE;
    logic [7:0] cfg_data  = '0;

    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       o_cfg_ready;

    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int unsigned cycle_count = 0;

    scanline_scoreboard sb;

    lcd_scanline_mode_timer dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: check what is taken, then pick the next ready value.
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready)
            sb.check_result(o_out_data);
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic t_in_item tick_req(logic [4:0] count);
        t_in_item req;
        req.mode   = REQ_TICK;
        req.cycles = count;
        req.lcd_on = 1'($urandom_range(0, 1));
        return req;
    endfunction

    function automatic t_in_item enable_req(logic on);
        t_in_item req;
        req.mode   = REQ_ENABLE;
        req.cycles = 5'($urandom_range(0, 31));
        req.lcd_on = on;
        return req;
    endfunction

    // Mostly long ticks so that whole frames get walked; turning the display
    // off is rare because it throws the line count back to zero.
    function automatic t_in_item random_request(logic display_on);
        if (!display_on) begin
            if ($urandom_range(0, 99) < 30)
                return enable_req(1'b1);
            return tick_req(5'($urandom_range(0, 31)));
        end
        if ($urandom_range(0, 399) == 0)
            return enable_req(1'b0);
        if ($urandom_range(0, 99) < 3)
            return enable_req(1'b1);
        if ($urandom_range(0, 99) < 70)
            return tick_req(5'($urandom_range(16, 31)));
        return tick_req(5'($urandom_range(0, 31)));
    endfunction

    // Called at a clock edge; returns at the edge where the request is taken
    // and leaves valid high so a back-to-back request needs no second write.
    task automatic drive_request(input t_in_item req);
        if ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
    endtask

    task automatic end_requests();
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, value);
    endtask

    // The upper nibble of the enables write is junk that must be dropped.
    task automatic configure(input logic [7:0] compare_line, input logic [3:0] enables);
        write_register(CFG_LINE_COMPARE, compare_line);
        write_register(CFG_IRQ_ENABLES, {4'($urandom_range(0, 15)), enables});
        cfg_valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // Writes to unused indexes must not disturb the real registers.
        write_register(CFG_UNUSED_2, 8'hFF);
        write_register(CFG_UNUSED_3, 8'hA5);
        configure(8'd1, 4'hF);

        // Display off: ticks change nothing, rewriting off is a no-op.
        drive_request(tick_req(5'd31));
        drive_request(tick_req(5'd0));
        drive_request(enable_req(1'b0));
        // Switch on into OAM scan, then a redundant enable.
        drive_request(enable_req(1'b1));
        drive_request(enable_req(1'b1));
        drive_request(tick_req(5'd0));
        // Saturated tick closes OAM scan, transfer ends on an exact 43.
        drive_request(tick_req(5'd31));
        drive_request(tick_req(5'd20));
        drive_request(tick_req(5'd20));
        drive_request(tick_req(5'd3));
        // Hblank to line 1, which matches the compare line.
        drive_request(tick_req(5'd21));
        drive_request(tick_req(5'd20));
        drive_request(tick_req(5'd11));
        drive_request(tick_req(5'd25));
        // Off mid-line clears line and coincidence, then back on.
        drive_request(enable_req(1'b0));
        drive_request(tick_req(5'd20));
        drive_request(enable_req(1'b1));
        // Full ticks so the remainder carries across transitions.
        repeat (6) drive_request(tick_req(5'd20));

        for (int p = 0; p < 4; p++) begin
            end_requests();
            wait_idle();
            case (p)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    configure(sb.line_count + 8'($urandom_range(0, 6)), 4'hF);
                end
                1: begin
                    idle_pct  = 55;
                    stall_pct = 0;
                    configure(8'hFF, 4'h0);
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 55;
                    configure(8'h00, 4'($urandom_range(1, 14)));
                end
                default: begin
                    idle_pct  = 34;
                    stall_pct = 34;
                    configure(sb.line_count + 8'($urandom_range(0, 6)), 4'hF);
                end
            endcase
            repeat (ITEMS_PER_PHASE) drive_request(random_request(sb.display_on));
        end

        end_requests();
        wait_idle();
        repeat (4) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
